[rtl/core/dle_stuffed_frame_parser_assert.svh]
// Assertion macros shared by the frame parser modules.
`ifndef DLE_STUFFED_FRAME_PARSER_ASSERT_SVH
`define DLE_STUFFED_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside of reset.
`define DSFP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside of reset.
`define DSFP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/dsfp_pkg.sv]
// Shared types and constants of the byte-stuffed frame parser.
package dsfp_pkg;

   localparam logic [7:0] STX_BYTE  = 8'h02;
   localparam logic [7:0] DLE_BYTE  = 8'h10;
   localparam logic [7:0] REPLY_BIT = 8'h20;

   localparam int          LIMIT_W     = 9;
   localparam logic [8:0]  LIMIT_RESET = 9'd256;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   typedef enum logic [1:0] {
      TOK_DATA  = 2'd0,
      TOK_START = 2'd1,
      TOK_IDLE  = 2'd2
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [7:0]   value;
   } token_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_GOOD = 2'd1,
      KIND_BAD  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_HUNT = 3'd0,
      ST_CMD  = 3'd1,
      ST_ADDR = 3'd2,
      ST_LEN  = 3'd3,
      ST_BODY = 3'd4
   } field_state_type;

endpackage

[rtl/core/dsfp_front.sv]
// Front end: resolves DLE escapes and classifies each received byte into a token.
module dsfp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_opcode,
   input  logic [7:0]          req_rx_byte,
   input  logic                queue_ready,
   output logic                push_valid,
   output dsfp_pkg::token_type push_token
);

   logic escape_ff;
   logic escape_in;
   logic emit;
   logic accept;

   assign req_ready = queue_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      escape_in        = escape_ff;
      emit             = 1'b0;
      push_token.kind  = dsfp_pkg::TOK_DATA;
      push_token.value = req_rx_byte;
      if (req_opcode) begin
         escape_in       = 1'b0;
         emit            = 1'b1;
         push_token.kind = dsfp_pkg::TOK_IDLE;
      end else if (req_rx_byte == dsfp_pkg::STX_BYTE) begin
         emit      = 1'b1;
         escape_in = 1'b0;
         if (!escape_ff) begin
            push_token.kind = dsfp_pkg::TOK_START;
         end
      end else if (req_rx_byte == dsfp_pkg::DLE_BYTE) begin
         escape_in = !escape_ff;
         emit      = escape_ff;
      end else begin
         emit = !escape_ff;
      end
   end

   assign push_valid = accept && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         escape_ff <= 1'b0;
      end else if (accept) begin
         escape_ff <= escape_in;
      end
   end

endmodule

[rtl/core/dsfp_fifo.sv]
// Short token queue between the front end and the frame parser.
`include "dle_stuffed_frame_parser_assert.svh"

module dsfp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  dsfp_pkg::token_type push_token,
   output logic                push_ready,
   output logic                pop_valid,
   input  logic                pop,
   output dsfp_pkg::token_type pop_token
);

   dsfp_pkg::token_type                entry_ff [dsfp_pkg::FIFO_DEPTH];
   logic [dsfp_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff;
   logic [dsfp_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff;
   logic [dsfp_pkg::FIFO_CNT_W-1:0]    count_ff;
   logic [dsfp_pkg::FIFO_CNT_W-1:0]    count_in;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = (count_ff != dsfp_pkg::FIFO_CNT_W'(dsfp_pkg::FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_token  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_token;
      end
   end

   `DSFP_ASSERT_NOW(a_no_push_when_full, push_valid, push_ready, "token pushed into a full queue")
   `DSFP_ASSERT_NEXT(a_push_lands, do_push && !do_pop, count_ff != '0, "pushed token lost")

endmodule

[rtl/core/dsfp_back.sv]
// Back end: frame field sequencing, checksum and result register.
`include "dle_stuffed_frame_parser_assert.svh"

module dsfp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                tok_valid,
   input  dsfp_pkg::token_type tok,
   output logic                pop,
   input  logic [8:0]          payload_limit,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_command,
   output logic [7:0]          rsp_address,
   output logic [7:0]          rsp_length,
   output logic [7:0]          rsp_data_byte,
   output logic [7:0]          rsp_byte_index,
   output logic                rsp_truncated
);

   dsfp_pkg::field_state_type state_ff, state_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] cmd_ff, cmd_in;
   logic [7:0] addr_ff, addr_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] count_ff, count_in;
   logic       ovf_ff, ovf_in;

   logic                rsp_valid_ff, rsp_valid_in;
   dsfp_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_command_ff, rsp_command_in;
   logic [7:0]          rsp_address_ff, rsp_address_in;
   logic [7:0]          rsp_length_ff, rsp_length_in;
   logic [7:0]          rsp_data_ff, rsp_data_in;
   logic [7:0]          rsp_index_ff, rsp_index_in;
   logic                rsp_trunc_ff, rsp_trunc_in;

   logic       out_free;
   logic       emit;
   logic [8:0] next_pos;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = tok_valid && out_free;
   assign next_pos = {1'b0, count_ff} + 9'd1;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      cmd_in         = cmd_ff;
      addr_in        = addr_ff;
      len_in         = len_ff;
      count_in       = count_ff;
      ovf_in         = ovf_ff;
      emit           = 1'b0;
      rsp_kind_in    = dsfp_pkg::KIND_DATA;
      rsp_data_in    = 8'd0;
      rsp_index_in   = 8'd0;
      if (pop) begin
         case (tok.kind)
            dsfp_pkg::TOK_IDLE: begin
               state_in = dsfp_pkg::ST_HUNT;
               sum_in   = 8'd0;
               cmd_in   = 8'd0;
               addr_in  = 8'd0;
               len_in   = 8'd0;
               count_in = 8'd0;
               ovf_in   = 1'b0;
            end
            dsfp_pkg::TOK_START: begin
               state_in = dsfp_pkg::ST_CMD;
               sum_in   = 8'd0;
               cmd_in   = 8'd0;
               len_in   = 8'd0;
               count_in = 8'd0;
               ovf_in   = 1'b0;
            end
            dsfp_pkg::TOK_DATA: begin
               case (state_ff)
                  dsfp_pkg::ST_CMD: begin
                     sum_in = sum_ff + tok.value;
                     if ((tok.value & dsfp_pkg::REPLY_BIT) != 8'd0) begin
                        cmd_in   = tok.value;
                        state_in = dsfp_pkg::ST_ADDR;
                     end else begin
                        cmd_in   = 8'd0;
                        state_in = dsfp_pkg::ST_HUNT;
                     end
                  end
                  dsfp_pkg::ST_ADDR: begin
                     addr_in  = tok.value;
                     sum_in   = sum_ff + tok.value;
                     state_in = dsfp_pkg::ST_LEN;
                  end
                  dsfp_pkg::ST_LEN: begin
                     len_in   = tok.value;
                     count_in = 8'd0;
                     sum_in   = sum_ff + tok.value;
                     state_in = dsfp_pkg::ST_BODY;
                  end
                  dsfp_pkg::ST_BODY: begin
                     if (count_ff < len_ff) begin
                        count_in = count_ff + 8'd1;
                        sum_in   = sum_ff + tok.value;
                        if (next_pos < payload_limit) begin
                           emit         = 1'b1;
                           rsp_kind_in  = dsfp_pkg::KIND_DATA;
                           rsp_data_in  = tok.value;
                           rsp_index_in = count_ff;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end else begin
                        state_in    = dsfp_pkg::ST_HUNT;
                        emit        = 1'b1;
                        rsp_kind_in = (tok.value == sum_ff) ? dsfp_pkg::KIND_GOOD
                                                            : dsfp_pkg::KIND_BAD;
                     end
                  end
                  default: begin
                     state_in = state_ff;
                  end
               endcase
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
      rsp_command_in = cmd_ff;
      rsp_address_in = addr_ff;
      rsp_length_in  = len_ff;
      rsp_trunc_in   = ovf_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsfp_pkg::ST_HUNT;
         sum_ff       <= 8'd0;
         cmd_ff       <= 8'd0;
         addr_ff      <= 8'd0;
         len_ff       <= 8'd0;
         count_ff     <= 8'd0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         cmd_ff       <= cmd_in;
         addr_ff      <= addr_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_command_ff <= rsp_command_in;
         rsp_address_ff <= rsp_address_in;
         rsp_length_ff  <= rsp_length_in;
         rsp_data_ff    <= rsp_data_in;
         rsp_index_ff   <= rsp_index_in;
         rsp_trunc_ff   <= rsp_trunc_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_command    = rsp_command_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_truncated  = rsp_trunc_ff;

   `DSFP_ASSERT_NOW(a_pop_frees_output, pop && rsp_valid_ff, rsp_ready, "token consumed while the result register is held")
   `DSFP_ASSERT_NEXT(a_frame_end_hunts, emit && (rsp_kind_in != dsfp_pkg::KIND_DATA), state_ff == dsfp_pkg::ST_HUNT, "parser did not return to hunting after a frame end")
   `DSFP_ASSERT_NOW(a_index_in_length, rsp_valid_ff && (rsp_kind_ff == dsfp_pkg::KIND_DATA), rsp_index_ff < len_ff, "payload index beyond the declared length")

endmodule

[rtl/core/dle_stuffed_frame_parser.sv]
// Top level of the STX/DLE byte-stuffed frame parser with additive checksum.
// The parser sustains one received byte per clock cycle while the queue has
// room. A front end resolves DLE escapes and pushes tokens into a four-entry
// queue; the frame parser pops one token per cycle whenever its output
// register is empty or being transferred, and registers each result there.
// Input is accepted as long as the queue has room, even while a result waits.
// The payload limit register may be written only while the parser is idle.
module dle_stuffed_frame_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_command,
   output logic [7:0] rsp_address,
   output logic [7:0] rsp_length,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_index,
   output logic       rsp_truncated,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data
);

   logic [dsfp_pkg::LIMIT_W-1:0] limit_ff;
   logic                         push_valid;
   dsfp_pkg::token_type          push_token;
   logic                         queue_ready;
   logic                         tok_valid;
   dsfp_pkg::token_type          tok;
   logic                         pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dsfp_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   dsfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .queue_ready (queue_ready),
      .push_valid  (push_valid),
      .push_token  (push_token)
   );

   dsfp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_token (push_token),
      .push_ready (queue_ready),
      .pop_valid  (tok_valid),
      .pop        (pop),
      .pop_token  (tok)
   );

   dsfp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .tok_valid      (tok_valid),
      .tok            (tok),
      .pop            (pop),
      .payload_limit  (limit_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_command    (rsp_command),
      .rsp_address    (rsp_address),
      .rsp_length     (rsp_length),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_truncated  (rsp_truncated)
   );

endmodule
